### rtl/lsbi_pkg.sv
// Shared types, codes and default sizes for the LIFO stack with bottom insert.
package lsbi_pkg;

    // Fixed widths of the request and result fields.
    localparam int FUNC_W      = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // Default sizes of the store.
    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    // Depth of the request queue between front and back.
    localparam int Q_DEPTH = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TOP    = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

    // A decoded request as it waits in the queue.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   depth_off;
    } cmd_t;

    // Head of the queue as the back engine sees it.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

endpackage

### rtl/lsbi_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module lsbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lsbi_front.sv
// Request front end: decodes incoming requests and queues them for the back engine.
module lsbi_front import lsbi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [VALUE_W-1:0] value,
    input  logic [POS_W-1:0]   position,
    output qhead_t             q_head,
    input  logic               q_pop
);

    localparam int QPTR_W = $clog2(Q_DEPTH);
    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    cmd_t              q_mem_reg [Q_DEPTH];
    cmd_t              cmd_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              q_push;

    // Positions zero and one both name the top entry.
    always_comb
    begin
        cmd_next.func      = func;
        cmd_next.value     = value;
        cmd_next.depth_off = (position <= POS_W'(1)) ? '0 : position - POS_W'(1);
    end

    assign in_stall = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign q_push   = in_valid && !in_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (q_push && !q_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (!q_push && q_pop)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_next;
        end
    end

    assign q_head.valid = (cnt_reg != '0);
    assign q_head.cmd   = q_mem_reg[rd_ptr_reg];

endmodule

### rtl/lsbi_back.sv
// Back engine: keeps the ring pointers, drives the entry RAM and holds the result register.
module lsbi_back import lsbi_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qhead_t                 q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [VALUE_W-1:0]     data_out,
    output logic [STATUS_W-1:0]    status,
    output logic [COUNT_OUT_W-1:0] count_out
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic S_EXEC = 1'b0;
    localparam logic S_WAIT = 1'b1;

    logic                   state_reg, state_next;
    logic [IDX_W-1:0]       top_reg, top_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       pend_count_reg, pend_count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     out_data_reg, out_data_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic                   out_free;
    logic                   is_full;
    logic                   is_empty;
    logic                   peek_range;
    logic [IDX_W-1:0]       top_dec;
    logic [CNT_W-1:0]       ring_off;
    logic [IDX_W-1:0]       ring_idx;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    logic                   load;
    logic [VALUE_W-1:0]     ld_data;
    logic [STATUS_W-1:0]    ld_status;
    logic [CNT_W-1:0]       ld_count;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    assign out_free   = !out_valid_reg || !out_stall;
    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign peek_range = (CMP_W'(q_head.cmd.depth_off) >= CMP_W'(count_reg));
    assign top_dec    = (top_reg == '0) ? IDX_W'(DEPTH - 1) : top_reg - IDX_W'(1);

    // One ring adder serves the append slot, the peek slot and the new top after a pop.
    always_comb
    begin
        case (q_head.cmd.func)
            FUNC_APPEND: ring_off = count_reg;
            FUNC_PEEK:   ring_off = CNT_W'(q_head.cmd.depth_off);
            default:     ring_off = CNT_W'(1);
        endcase
    end

    assign ring_idx = ring_add(top_reg, ring_off);

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        count_next      = count_reg;
        pend_count_next = pend_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = top_dec;
        ram_wdata       = WORD_BITS'(q_head.cmd.value);
        ram_re          = 1'b0;
        ram_raddr       = top_reg;
        load            = 1'b0;
        ld_data         = '0;
        ld_status       = STAT_OK;
        ld_count        = count_reg;

        case (state_reg)
            S_EXEC:
            begin
                if (q_head.valid)
                begin
                    case (q_head.cmd.func)
                        FUNC_PUSH, FUNC_APPEND:
                        begin
                            if (out_free)
                            begin
                                q_pop = 1'b1;
                                load  = 1'b1;
                                if (is_full)
                                begin
                                    ld_status = STAT_FULL;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                    ld_count   = count_reg + CNT_W'(1);
                                    if (q_head.cmd.func == FUNC_PUSH)
                                    begin
                                        ram_waddr = top_dec;
                                        top_next  = top_dec;
                                    end
                                    else
                                    begin
                                        ram_waddr = ring_idx;
                                    end
                                end
                            end
                        end
                        FUNC_POP, FUNC_PEEK, FUNC_TOP:
                        begin
                            if (is_empty || (q_head.cmd.func == FUNC_PEEK && peek_range))
                            begin
                                if (out_free)
                                begin
                                    q_pop     = 1'b1;
                                    load      = 1'b1;
                                    ld_data   = '1;
                                    ld_status = is_empty ? STAT_EMPTY : STAT_RANGE;
                                end
                            end
                            else
                            begin
                                q_pop           = 1'b1;
                                ram_re          = 1'b1;
                                pend_count_next = count_reg;
                                state_next      = S_WAIT;
                                if (q_head.cmd.func == FUNC_PEEK)
                                begin
                                    ram_raddr = ring_idx;
                                end
                                if (q_head.cmd.func == FUNC_POP)
                                begin
                                    top_next        = ring_idx;
                                    count_next      = count_reg - CNT_W'(1);
                                    pend_count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                q_pop = 1'b1;
                                load  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_data    = VALUE_W'($signed(ram_rdata));
                    ld_count   = pend_count_reg;
                    state_next = S_EXEC;
                end
            end
            default:
            begin
                state_next = S_EXEC;
            end
        endcase

        if (load)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = ld_data;
            out_status_next = ld_status;
            out_count_next  = COUNT_OUT_W'(ld_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EXEC;
            top_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_count_reg <= pend_count_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    lsbi_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign status    = out_status_reg;
    assign count_out = out_count_reg;

endmodule

### rtl/lifo_stack_with_bottom_insert.sv
// Top level of the bounded LIFO stack with bottom insert.
//
// This block is a bounded stack of signed words held in a ring of DEPTH RAM entries, addressed
// by a top pointer and an entry count. Each request carries one operation (push on top, append
// at the bottom, pop, peek at a position counted from the top, or read the top) and yields
// exactly one result with a data word, a status code and the entry count after the step.
// Requests land in a two-deep queue in the front end, so the input side keeps accepting
// requests while the back engine waits on a stalled output, until the queue fills. A push, an
// append, any refused or failing request and any unused operation code complete in the back
// engine's execute state; a successful pop, peek or read of the top also passes through a wait
// state, because the entry RAM registers its read data. The back engine takes one request
// per cycle for writes and errors while the output is not stalled; while a successful read
// waits for its data, the next request stays in the queue. The RAM needs no clearing after
// reset since only live entries are ever read. Words are stored at WORD_BITS bits and
// sign-extended to the 32-bit result; count_out carries the low seven bits of the entry count.
module lifo_stack_with_bottom_insert import lsbi_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FUNC_W-1:0]      func,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [POS_W-1:0]       position,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [VALUE_W-1:0] data_out,
    output logic [STATUS_W-1:0]    status,
    output logic [COUNT_OUT_W-1:0] count_out
);

    // Queue head travels from the front end to the back engine, the pop strobe comes back.
    qhead_t q_head;
    logic   q_pop;

    // The front end decodes the peek position and buffers requests.
    lsbi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .value    (value),
        .position (position),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    // The back engine owns the ring pointers, the entry RAM and the result register.
    lsbi_back #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .status    (status),
        .count_out (count_out)
    );

endmodule

### rtl/lsbi_checker.sv
// Port-level checker for the LIFO stack with bottom insert, bound to the top level.
module lsbi_checker import lsbi_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [VALUE_W-1:0]     data_out,
    input logic [STATUS_W-1:0]    status,
    input logic [COUNT_OUT_W-1:0] count_out
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(status)
            && $stable(count_out))
        else $error("stalled result changed");

    // A refused write reports a zero word and a full store.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> data_out == '0
            && count_out == COUNT_OUT_W'(DEPTH))
        else $error("full result inconsistent");

    // An empty result reports all ones and a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |-> data_out == '1 && count_out == '0)
        else $error("empty result inconsistent");

    // A peek past the count reports all ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_RANGE |-> data_out == '1)
        else $error("range result inconsistent");

endmodule

bind lifo_stack_with_bottom_insert lsbi_checker #(
    .DEPTH (DEPTH)
) u_lsbi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .status    (status),
    .count_out (count_out)
);
